// ----- src/fdi_pkg.sv -----
`default_nettype none
package fdi_pkg;

    localparam int DW = 64;
    localparam logic signed [DW-1:0] LIMV = 64'sh3FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [9:0] {
        S_LOAD  = 10'b00_0000_0001,
        S_CHECK = 10'b00_0000_0010,
        S_PDIV  = 10'b00_0000_0100,
        S_PASS  = 10'b00_0000_1000,
        S_RD    = 10'b00_0001_0000,
        S_WR    = 10'b00_0010_0000,
        S_MUL1  = 10'b00_0100_0000,
        S_DIV2  = 10'b00_1000_0000,
        S_MUL2  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic          neg;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic signed [DW-1:0] res;
    } t_unit_rsp;

    function automatic logic signed [DW-1:0] clamp64(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = v;
        if (v > LIMV) begin
            r = LIMV;
        end else if (v < -LIMV) begin
            r = -LIMV;
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] mag64(input logic signed [DW-1:0] v);
        return v[DW-1] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [DW-1:0] sign64(input logic [DW-1:0] m, input logic neg);
        logic [DW-1:0] c;
        c = (m[DW-1:DW-2] != 2'b00) ? LIMV : m;
        return neg ? -$signed(c) : $signed(c);
    endfunction

endpackage
`default_nettype wire

// ----- src/fdi_mul.sv -----
`default_nettype none
module fdi_mul
    import fdi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_mul_req   i_req,
    output t_unit_rsp  o_rsp
);

    logic [DW-1:0]     r_ua, r_ub;
    logic              r_neg;
    logic [2*DW-1:0]   r_acc;
    logic [DW-1:0]     r_pp;
    logic [1:0]        r_sh;
    logic [2:0]        r_k;
    logic              r_busy;
    logic              r_fin;
    t_unit_rsp         r_rsp;
    logic [31:0]       w_pa, w_pb;
    logic [1:0]        w_off;
    logic [2*DW-1:0]   w_add;
    logic [DW-1:0]     w_res;

    assign w_pa  = r_k[0] ? r_ua[63:32] : r_ua[31:0];
    assign w_pb  = r_k[1] ? r_ub[63:32] : r_ub[31:0];
    assign w_off = {1'b0, r_sh[0]} + {1'b0, r_sh[1]};
    assign w_add = {64'd0, r_pp} << {w_off, 5'd0};

    always_comb begin
        if (r_acc[2*DW-1:DW+FRAC_BITS] != '0) begin
            w_res = LIMV;
        end else begin
            w_res = r_acc[DW-1+FRAC_BITS:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rsp  <= '0;
            r_k    <= '0;
        end else begin
            r_fin      <= r_busy && !i_req.start && (r_k == 3'd4);
            r_rsp.done <= r_fin;
            if (r_fin) begin
                r_rsp.res <= sign64(w_res, r_neg);
            end
            if (i_req.start) begin
                r_ua   <= mag64(clamp64(i_req.a));
                r_ub   <= mag64(clamp64(i_req.b));
                r_neg  <= i_req.a[DW-1] ^ i_req.b[DW-1];
                r_acc  <= '0;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_k != 3'd4) begin
                    r_pp <= DW'(w_pa) * DW'(w_pb);
                    r_sh <= r_k[1:0];
                end
                if (r_k != 3'd0) begin
                    r_acc <= r_acc + w_add;
                end
                if (r_k == 3'd4) begin
                    r_busy <= 1'b0;
                end
                r_k <= r_k + 3'd1;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule
`default_nettype wire

// ----- src/fdi_div.sv -----
`default_nettype none
module fdi_div
    import fdi_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_div_req   i_req,
    output t_unit_rsp  o_rsp
);

    logic [DW-1:0] r_num, r_den, r_q;
    logic [DW:0]   r_rem;
    logic          r_neg;
    logic [5:0]    r_k;
    logic          r_busy;
    t_unit_rsp     r_rsp;
    logic [DW:0]   w_rem;
    logic          w_ge;

    assign w_rem = {r_rem[DW-1:0], r_num[DW-1]};
    assign w_ge  = w_rem >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rsp  <= '0;
            r_k    <= '0;
        end else begin
            r_rsp.done <= r_busy && !i_req.start && (r_k == 6'd63);
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_neg  <= i_req.neg;
                r_rem  <= '0;
                r_q    <= '0;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[DW-2:0], 1'b0};
                r_rem <= w_ge ? (w_rem - {1'b0, r_den}) : w_rem;
                r_q   <= {r_q[DW-2:0], w_ge};
                r_k   <= r_k + 6'd1;
                if (r_k == 6'd63) begin
                    r_busy    <= 1'b0;
                    r_rsp.res <= (r_den == '0) ? '0 :
                                 sign64({r_q[DW-2:0], w_ge}, r_neg);
                end
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule
`default_nettype wire

// ----- src/forward_difference_interpolator.sv -----
`default_nettype none
// Loading accepts one item per cycle, back to back, until the item marked last.
// The item marked last starts evaluation: the spacing division, then for each difference
// order i a difference pass, multiply, 64-step division by i and multiply-accumulate.
// The result moves to an output register and waits there until taken; a new set may load
// meanwhile; only the hand-over of that set's result waits while the register is full.
// Synchronous active-low reset clears control state; the sample store is not cleared.
module forward_difference_interpolator
    import fdi_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [95:0] i_s_axis_tdata,  // sample_x, sample_y, query_x
    input  wire         i_s_axis_tlast,  // last_sample
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata   // interp_value, status, zero fill
);

    localparam int WA = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int WC = $clog2(MAX_POINTS + 1);

    t_state               r_state;
    logic [WC-1:0]        r_pl, r_n, r_i, r_j;
    logic                 r_ovf;
    logic signed [31:0]   r_x0, r_x1, r_xq;
    logic signed [DW-1:0] r_d0, r_prev, r_p, r_coef, r_sum, r_rdata;
    logic signed [DW-1:0] r_mem [MAX_POINTS];
    logic [WA-1:0]        w_raddr, w_waddr;
    logic                 w_we;
    logic signed [DW-1:0] w_wdata, w_diff, w_xd, w_h, w_pm, w_sum;
    logic                 r_ovalid;
    logic signed [31:0]   r_oval, r_res;
    logic [1:0]           r_ostat, r_rstat;
    logic                 w_acc, w_last;
    logic signed [31:0]   w_sx, w_sy, w_q;
    t_mul_req             w_mreq;
    t_div_req             w_dreq;
    t_unit_rsp            w_mrsp, w_drsp;

    assign w_sx   = i_s_axis_tdata[31:0];
    assign w_sy   = i_s_axis_tdata[63:32];
    assign w_q    = i_s_axis_tdata[95:64];
    assign w_last = i_s_axis_tlast;
    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;

    assign w_xd   = 64'(r_xq) - 64'(r_x0);
    assign w_h    = 64'(r_x1) - 64'(r_x0);
    assign w_diff = clamp64(r_rdata - r_prev);
    assign w_pm   = clamp64(r_p - ($signed({{(DW-WC){1'b0}}, r_i} - 64'sd1) <<< FRAC_BITS));
    assign w_sum  = clamp64(r_sum + w_mrsp.res);

    fdi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_rsp  (w_mrsp)
    );

    fdi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    always_comb begin
        w_mreq = '0;
        w_dreq = '0;
        if (r_state == S_CHECK) begin
            w_dreq.start = !r_ovf && (r_n != WC'(1)) && (w_h != '0);
            w_dreq.num   = mag64(w_xd) << FRAC_BITS;
            w_dreq.den   = mag64(w_h);
            w_dreq.neg   = w_xd[DW-1] ^ w_h[DW-1];
        end
        if (r_state == S_PASS && r_j == '0) begin
            w_mreq = '0;
        end
        if (r_state == S_WR && (r_j == r_n - r_i - WC'(1))) begin
            w_mreq.start = 1'b1;
            w_mreq.a     = r_coef;
            w_mreq.b     = w_pm;
        end
        if (r_state == S_MUL1 && w_mrsp.done) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = mag64(w_mrsp.res);
            w_dreq.den   = {{(DW-WC){1'b0}}, r_i};
            w_dreq.neg   = w_mrsp.res[DW-1];
        end
        if (r_state == S_DIV2 && w_drsp.done) begin
            w_mreq.start = 1'b1;
            w_mreq.a     = w_drsp.res;
            w_mreq.b     = r_d0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_j[WA-1:0];
        w_wdata = w_diff;
        w_raddr = WA'(r_j + WC'(1));
        if (w_acc && r_pl < WC'(MAX_POINTS)) begin
            w_we    = 1'b1;
            w_waddr = r_pl[WA-1:0];
            w_wdata = 64'(w_sy);
        end else if (r_state == S_WR) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_pl     <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_x0     <= '0;
            r_x1     <= '0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (r_pl < WC'(MAX_POINTS)) begin
                            if (r_pl == '0) begin
                                r_x0 <= w_sx;
                                r_d0 <= 64'(w_sy);
                            end
                            if (r_pl == WC'(1)) begin
                                r_x1 <= w_sx;
                            end
                            r_pl <= r_pl + WC'(1);
                            r_n  <= r_pl + WC'(1);
                        end else begin
                            r_ovf <= 1'b1;
                            r_n   <= r_pl;
                        end
                        if (w_last) begin
                            r_xq    <= w_q;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_sum <= r_d0;
                    if (r_ovf) begin
                        r_res   <= '0;
                        r_rstat <= ST_OVF;
                        r_state <= S_DONE;
                    end else if (r_n == WC'(1)) begin
                        r_res   <= r_d0[31:0];
                        r_rstat <= ST_OK;
                        r_state <= S_DONE;
                    end else if (w_h == '0) begin
                        r_res   <= '0;
                        r_rstat <= ST_ZERO;
                        r_state <= S_DONE;
                    end else begin
                        r_res   <= '0;
                        r_rstat <= ST_OK;
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (w_drsp.done) begin
                        r_p     <= w_drsp.res;
                        r_coef  <= 64'sd1 <<< FRAC_BITS;
                        r_i     <= WC'(1);
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_prev  <= r_d0;
                    r_j     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_j == '0) begin
                        r_d0 <= w_diff;
                    end
                    r_prev <= r_rdata;
                    if (r_j == r_n - r_i - WC'(1)) begin
                        r_state <= S_MUL1;
                    end else begin
                        r_j     <= r_j + WC'(1);
                        r_state <= S_RD;
                    end
                end
                S_MUL1: begin
                    if (w_mrsp.done) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_drsp.done) begin
                        r_coef  <= w_drsp.res;
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (w_mrsp.done) begin
                        r_sum <= w_sum;
                        if (r_i == r_n - WC'(1)) begin
                            if (w_sum > 64'sd2147483647) begin
                                r_res <= 32'sh7FFF_FFFF;
                            end else if (w_sum < -64'sd2147483648) begin
                                r_res <= 32'sh8000_0000;
                            end else begin
                                r_res <= w_sum[31:0];
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_i     <= r_i + WC'(1);
                            r_state <= S_PASS;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_res;
                        r_ostat  <= r_rstat;
                        r_pl     <= '0;
                        r_ovf    <= 1'b0;
                        r_x0     <= '0;
                        r_x1     <= '0;
                        r_state  <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'd0, r_ostat, r_oval};

    a_pl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pl <= WC'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_last_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last) |=> (r_state == S_CHECK))
        else $error("last item did not start evaluation");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != ST_OK) |-> (r_oval == '0))
        else $error("error status with non-zero value");

    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mreq.start && w_dreq.start))
        else $error("both arithmetic units started together");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
    import fdi_pkg::*;

    localparam int NPTS = 16;
    localparam int FB = 16;
    localparam logic signed [63:0] QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG = 40000;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_interp;

    class interp_scoreboard;
        logic signed [31:0] ys [NPTS];
        logic signed [31:0] x0, x1;
        int unsigned        loaded;
        bit                 overflow;
        t_interp            pending[$];
        int                 errors;
        int                 checked;
        int unsigned        status_seen[3];

        function new();
            loaded = 0;
            overflow = 0;
            x0 = 0;
            x1 = 0;
            errors = 0;
            checked = 0;
        endfunction

        function logic signed [63:0] clampq(input logic signed [63:0] v);
            if (v > QLIM) return QLIM;
            if (v < -QLIM) return -QLIM;
            return v;
        endfunction

        function logic [63:0] magq(input logic signed [63:0] v);
            return v < 0 ? -v : v;
        endfunction

        function logic signed [63:0] signq(input logic [63:0] m, input bit neg);
            logic signed [63:0] r;
            if (m > QLIM) m = QLIM;
            r = m;
            return neg ? -r : r;
        endfunction

        function logic signed [63:0] mulq(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
            logic [127:0] prod;
            logic [63:0]  r;
            prod = magq(clampq(a)) * magq(clampq(b));
            if (prod[127:64+FB] != 0) r = QLIM;
            else r = prod[63+FB:FB];
            return signq(r, (a < 0) != (b < 0));
        endfunction

        function logic signed [63:0] divq(input logic signed [63:0] n,
                                          input logic signed [63:0] d);
            if (d == 0) return 0;
            return signq(magq(n) / magq(d), (n < 0) != (d < 0));
        endfunction

        function t_interp evaluate(input logic signed [63:0] xq);
            t_interp r;
            logic signed [63:0] d [NPTS];
            logic signed [63:0] h, p, coef, sum, dx;
            r.value = 0;
            r.status = ST_OK;
            if (overflow) begin
                r.status = ST_OVF;
                return r;
            end
            h = 64'(x1) - 64'(x0);
            if (loaded >= 2 && h == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            for (int i = 0; i < loaded; i++) d[i] = ys[i];
            sum = d[0];
            p = 0;
            if (loaded >= 2) begin
                dx = xq - 64'(x0);
                p = divq(signq(magq(dx) << FB, dx < 0), h);
            end
            coef = 64'sd1 <<< FB;
            for (int i = 1; i < loaded; i++) begin
                for (int j = 0; j + i < loaded; j++) d[j] = clampq(d[j+1] - d[j]);
                coef = mulq(coef, clampq(p - (64'(i - 1) <<< FB)));
                coef = divq(coef, 64'(i));
                sum = clampq(sum + mulq(coef, d[0]));
            end
            if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
            if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
            r.value = sum[31:0];
            return r;
        endfunction

        function void note_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                                  input bit last, input logic signed [31:0] xq);
            if (loaded < NPTS) begin
                if (loaded == 0) x0 = x;
                if (loaded == 1) x1 = x;
                ys[loaded] = y;
                loaded++;
            end else begin
                overflow = 1;
            end
            if (last) begin
                pending.push_back(evaluate(64'(xq)));
                loaded = 0;
                overflow = 0;
                x0 = 0;
                x1 = 0;
            end
        endfunction

        function void check_result(input logic [39:0] data);
            t_interp e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            status_seen[e.status]++;
            if (data[31:0] !== e.value) begin
                $error("interp_value: expected %0d, actual %0d", e.value, $signed(data[31:0]));
                errors++;
            end
            if (data[33:32] !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, data[33:32]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [95:0] s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_data;

    interp_scoreboard board;
    int  idle_cycles;
    bit  driving_done;
    bit  hold_off;
    int  samples_sent;

    forward_difference_interpolator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_sample(input logic [31:0] x, input logic [31:0] y, input bit last,
                               input logic [31:0] xq);
        int gap;
        s_valid <= 1;
        s_data <= {xq, y, x};
        s_last <= last;
        do @(posedge i_clk); while (!s_ready);
        board.note_sample(x, y, last, xq);
        samples_sent++;
        @(negedge i_clk);
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // A set of n points on a uniform grid with base x0 and spacing h.
    task automatic send_set(input int n, input logic [31:0] x0, input logic [31:0] h,
                            input bit wild_y, input logic [31:0] xq);
        logic [31:0] y;
        for (int i = 0; i < n; i++) begin
            y = wild_y ? $urandom : 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
            send_sample(x0 + h * i, y, i == n - 1, xq);
        end
    endtask

    task automatic send_random_set();
        int n, kind;
        logic [31:0] x0, h, xq;
        kind = $urandom_range(0, 99);
        n = $urandom_range(1, 8);
        if (kind < 10) n = $urandom_range(9, NPTS);
        if (kind >= 95) n = $urandom_range(NPTS + 1, NPTS + 4);
        x0 = $urandom_range(0, 99) < 80 ? 32'($signed($urandom_range(0, 32'h00FF_FFFF))
             - 32'h0080_0000) : $urandom;
        h = $urandom_range(0, 99) < 85 ? $urandom_range(32'h0000_4000, 32'h0004_0000) : $urandom;
        if ($urandom_range(0, 99) < 4) h = 0;
        if ($urandom_range(0, 1)) h = -h;
        xq = $urandom_range(0, 99) < 75 ? x0 + $signed(h) * $urandom_range(0, n) / 2 : $urandom;
        send_set(n, x0, h, $urandom_range(0, 99) < 20, xq);
    endtask

    initial begin
        board = new();
        i_rst_n = 0;
        s_valid = 0;
        s_data = '0;
        s_last = 0;
        driving_done = 0;
        samples_sent = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF);
        send_set(2, 32'h0001_0000, 32'h0, 0, 32'h0001_8000);
        send_set(NPTS, 32'h0, 32'h0001_0000, 0, 32'h0003_8000);
        send_set(NPTS + 1, 32'h0, 32'h0001_0000, 0, 32'h0);
        send_set(3, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF);
        send_set(5, 32'hFFFF_0000, 32'hFFFF_C000, 1, 32'h8000_0000);
        send_set(NPTS, 32'h0, 32'h0000_0001, 1, 32'h7FFF_FFFF);
        while (samples_sent < 1750) send_random_set();
        s_valid <= 0;
        driving_done = 1;
    end

    initial begin
        m_ready = 0;
        hold_off = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (samples_sent > 300 && samples_sent < 320 && !hold_off) begin
                hold_off = 1;
                m_ready <= 0;
                repeat (3000) @(negedge i_clk);
            end else if ($urandom_range(0, 99) < 20) begin
                m_ready <= 0;
                repeat (gap_length() + 1) @(negedge i_clk);
            end
            m_ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) board.check_result(m_data);
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        wait (driving_done && board.pending.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d samples; checked %0d results (ok %0d, zero spacing %0d, overflow %0d).",
                 samples_sent, board.checked, board.status_seen[0], board.status_seen[1],
                 board.status_seen[2]);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG);
        $display("Watchdog expired after %0d idle cycles.", WATCHDOG);
        $display("simulation failed");
        $finish;
    end
endmodule
